### hw/rtl/lsfd_pkg.sv
// ----------------------------------------------------------------------------
// lsfd_pkg
// Shared types and constants of the lidar scan frame decoder.
// ----------------------------------------------------------------------------
package lsfd_pkg;

  localparam logic [7:0] HDR_BYTE0 = 8'hAA;
  localparam logic [7:0] HDR_BYTE1 = 8'h55;

  // Frame positions of the header fields that the decoder needs.
  localparam int POS_FIRST_DATA = 2;
  localparam int POS_COUNT      = 3;
  localparam int POS_START_LO   = 4;
  localparam int POS_START_HI   = 5;
  localparam int POS_END_LO     = 6;
  localparam int POS_END_HI     = 7;
  // Point k takes its distance from positions 2k+10 and 2k+11.
  localparam int DIST_BASE      = 10;

  localparam int CNT_MAX  = 40;
  localparam int CNT_W    = 6;
  localparam int ANG_W    = 9;
  localparam int SPAN_W   = 11;
  localparam int DIV_BITS = 10;
  localparam int DIST_W   = 14;
  localparam int OUT_ANG_W = 10;

  localparam logic [SPAN_W-1:0] ANGLE_FULL = 11'd360;

  typedef struct packed {
    logic                     bank;
    logic [CNT_W-1:0]         last_k;
    logic [ANG_W-1:0]         start;
    logic signed [SPAN_W-1:0] span;
  } frame_desc_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } bank_rel_t;

endpackage

### hw/rtl/lsfd_ram.sv
// ----------------------------------------------------------------------------
// lsfd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lsfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/lsfd_desc_fifo.sv
// ----------------------------------------------------------------------------
// lsfd_desc_fifo
// Two-entry queue of completed frame descriptors between front and back.
// ----------------------------------------------------------------------------
module lsfd_desc_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  lsfd_pkg::frame_desc_t push_desc,
  input  logic                 pop,
  output logic                 head_valid,
  output lsfd_pkg::frame_desc_t head_desc
);
  import lsfd_pkg::*;

  frame_desc_t entry_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  fill_r, fill_nxt;
  logic        do_push, do_pop;

  assign do_push    = push && (fill_r != 2'd2);
  assign do_pop     = pop && (fill_r != 2'd0);
  assign head_valid = (fill_r != 2'd0);
  assign head_desc  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

### hw/rtl/lsfd_front.sv
// ----------------------------------------------------------------------------
// lsfd_front
// Header hunt, frame byte storage and frame descriptor generation.
// ----------------------------------------------------------------------------
module lsfd_front #(
  parameter int FRAME_BYTES = 90,
  parameter int POS_W       = 7
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,
  output logic                 ram_we,
  output logic [POS_W:0]       ram_waddr,
  output logic [7:0]           ram_wdata,
  output logic                 push,
  output lsfd_pkg::frame_desc_t push_desc,
  input  lsfd_pkg::bank_rel_t   rel
);
  import lsfd_pkg::*;

  localparam int FIT_CNT   = (FRAME_BYTES - 10) / 2;
  localparam int CLAMP_CNT = (FIT_CNT < CNT_MAX) ? FIT_CNT : CNT_MAX;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             bank_r, bank_nxt;
  logic [1:0]       busy_r, busy_nxt;
  logic [7:0]       cnt_byte_r;
  logic             start_lsb_r;
  logic [7:0]       start_hi_r;
  logic             end_lsb_r;
  logic [7:0]       end_hi_r;

  logic             accept;
  logic             storing;
  logic             is_last;
  logic [CNT_W-1:0] cnt_clamped;
  logic [ANG_W-1:0] ang_start;
  logic [ANG_W-1:0] ang_stop;
  logic [SPAN_W-1:0] span_raw;

  assign storing   = (pos_r >= POS_W'(POS_FIRST_DATA));
  assign in_tready = !(storing && busy_r[bank_r]);
  assign accept    = in_tvalid && in_tready;
  assign is_last   = (pos_r == POS_W'(FRAME_BYTES - 1));

  assign ram_we    = accept && storing;
  assign ram_waddr = {bank_r, pos_r};
  assign ram_wdata = in_tdata;

  // The angle fields are ((hi << 7) + (lo >> 1)) / 64, which keeps hi and lo[7].
  assign ang_start = {start_hi_r, start_lsb_r};
  assign ang_stop  = {end_hi_r, end_lsb_r};

  always_comb begin
    if (cnt_byte_r > 8'(CLAMP_CNT)) begin
      cnt_clamped = CNT_W'(CLAMP_CNT);
    end else begin
      cnt_clamped = cnt_byte_r[CNT_W-1:0];
    end
    if (ang_stop < ang_start) begin
      span_raw = ANGLE_FULL - {2'b00, ang_start} + {2'b00, ang_stop};
    end else begin
      span_raw = {2'b00, ang_stop} - {2'b00, ang_start};
    end
  end

  assign push = accept && storing && is_last && (cnt_clamped >= CNT_W'(2));

  always_comb begin
    push_desc.bank   = bank_r;
    push_desc.last_k = cnt_clamped - CNT_W'(1);
    push_desc.start  = ang_start;
    push_desc.span   = $signed(span_raw);
  end

  always_comb begin
    pos_nxt  = pos_r;
    bank_nxt = bank_r;
    busy_nxt = busy_r;
    if (rel.valid) begin
      busy_nxt[rel.bank] = 1'b0;
    end
    if (push) begin
      busy_nxt[bank_r] = 1'b1;
      bank_nxt         = ~bank_r;
    end
    if (accept) begin
      if (pos_r == POS_W'(0)) begin
        pos_nxt = (in_tdata == HDR_BYTE0) ? POS_W'(1) : POS_W'(0);
      end else if (pos_r == POS_W'(1)) begin
        pos_nxt = (in_tdata == HDR_BYTE1) ? POS_W'(POS_FIRST_DATA) : POS_W'(0);
      end else if (is_last) begin
        pos_nxt = POS_W'(0);
      end else begin
        pos_nxt = pos_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      bank_r <= 1'b0;
      busy_r <= 2'b00;
    end else begin
      pos_r  <= pos_nxt;
      bank_r <= bank_nxt;
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (pos_r == POS_W'(POS_COUNT)) begin
        cnt_byte_r <= in_tdata;
      end
      if (pos_r == POS_W'(POS_START_LO)) begin
        start_lsb_r <= in_tdata[7];
      end
      if (pos_r == POS_W'(POS_START_HI)) begin
        start_hi_r <= in_tdata;
      end
      if (pos_r == POS_W'(POS_END_LO)) begin
        end_lsb_r <= in_tdata[7];
      end
      if (pos_r == POS_W'(POS_END_HI)) begin
        end_hi_r <= in_tdata;
      end
    end
  end

endmodule

### hw/rtl/lsfd_back.sv
// ----------------------------------------------------------------------------
// lsfd_back
// Per-frame step division and point generation from the stored frame.
// ----------------------------------------------------------------------------
module lsfd_back #(
  parameter int POS_W = 7
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  lsfd_pkg::frame_desc_t q_desc,
  output logic                 q_pop,
  output logic [POS_W:0]       ram_raddr,
  input  logic [7:0]           ram_rdata,
  output lsfd_pkg::bank_rel_t   rel,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [23:0]          out_tdata,
  output logic                 out_tuser,
  output logic                 out_tlast
);
  import lsfd_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_FIN  = 3'd2;
  localparam logic [2:0] ST_RDLO = 3'd3;
  localparam logic [2:0] ST_RDHI = 3'd4;
  localparam logic [2:0] ST_CAPT = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  logic [2:0]               state_r, state_nxt;
  logic                     bank_r;
  logic [CNT_W-1:0]         last_k_r;
  logic [CNT_W-1:0]         k_r;
  logic [ANG_W-1:0]         start_r;
  logic                     neg_r;
  logic [DIV_BITS-1:0]      quo_r;
  logic [CNT_W-1:0]         rem_r;
  logic [3:0]               div_cnt_r;
  logic signed [SPAN_W-1:0] step_r;
  logic signed [SPAN_W-1:0] ang_r;
  logic [7:0]               lo_r;
  logic [DIST_W-1:0]        dist_r;

  logic [SPAN_W-1:0]        span_abs;
  logic [CNT_W:0]           trial;
  logic                     trial_ge;
  logic signed [SPAN_W-1:0] step_fin;
  logic [POS_W-1:0]         pos_lo;
  logic                     is_last_pt;

  assign q_pop      = (state_r == ST_IDLE) && q_valid;
  assign span_abs   = q_desc.span[SPAN_W-1] ? SPAN_W'(-q_desc.span) : q_desc.span;
  assign trial      = {rem_r, quo_r[DIV_BITS-1]};
  assign trial_ge   = (trial >= {1'b0, last_k_r});
  assign step_fin   = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
  assign is_last_pt = (k_r == last_k_r);

  assign pos_lo = POS_W'({k_r, 1'b0}) + POS_W'(DIST_BASE);
  always_comb begin
    if (state_r == ST_RDHI) begin
      ram_raddr = {bank_r, pos_lo | POS_W'(1)};
    end else begin
      ram_raddr = {bank_r, pos_lo};
    end
  end

  assign out_tvalid = (state_r == ST_OUT);
  assign out_tdata  = {dist_r, ang_r[OUT_ANG_W-1:0]};
  // Angles are never negative, so an unsigned compare is exact.
  assign out_tuser  = ($unsigned(ang_r) < ANGLE_FULL);
  assign out_tlast  = is_last_pt;

  assign rel.valid = (state_r == ST_OUT) && out_tready && is_last_pt;
  assign rel.bank  = bank_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_cnt_r == 4'd1) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN:  state_nxt = ST_RDLO;
      ST_RDLO: state_nxt = ST_RDHI;
      ST_RDHI: state_nxt = ST_CAPT;
      ST_CAPT: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_tready) begin
          state_nxt = is_last_pt ? ST_IDLE : ST_RDLO;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          bank_r    <= q_desc.bank;
          last_k_r  <= q_desc.last_k;
          start_r   <= q_desc.start;
          neg_r     <= q_desc.span[SPAN_W-1];
          quo_r     <= span_abs[DIV_BITS-1:0];
          rem_r     <= '0;
          div_cnt_r <= 4'(DIV_BITS);
          k_r       <= CNT_W'(1);
        end
      end
      ST_DIV: begin
        // One restoring division step per cycle; the quotient shifts in at the bottom.
        if (trial_ge) begin
          rem_r <= CNT_W'(trial - {1'b0, last_k_r});
        end else begin
          rem_r <= trial[CNT_W-1:0];
        end
        quo_r     <= {quo_r[DIV_BITS-2:0], trial_ge};
        div_cnt_r <= div_cnt_r - 4'd1;
      end
      ST_FIN: begin
        step_r <= step_fin;
        ang_r  <= $signed({2'b00, start_r}) + step_fin;
      end
      ST_RDHI: begin
        lo_r <= ram_rdata;
      end
      ST_CAPT: begin
        dist_r <= {ram_rdata, lo_r[7:2]};
      end
      ST_OUT: begin
        if (out_tready && !is_last_pt) begin
          k_r   <= k_r + CNT_W'(1);
          ang_r <= ang_r + step_r;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### hw/rtl/lidar_scan_frame_decoder_core.sv
// ----------------------------------------------------------------------------
// lidar_scan_frame_decoder_core
// Lidar scan frame decoder: byte stream in, one transaction per sample point out.
// ----------------------------------------------------------------------------
// The input takes one byte per cycle. The front hunts for the 0xAA 0x55 header,
// stores the frame into one of two RAM banks and hands a descriptor to the back
// through a two-entry queue, so bytes of the next frame are taken while the
// previous frame is still being decoded; input stalls only if both banks still
// hold frames not yet fully emitted. Per frame the back runs a bit-serial
// division of the angle span by count-1, then for each point two registered
// RAM reads, a capture and an output state, plus any output stall. A frame of
// the default 90 bytes yields at most 39 points.
module lidar_scan_frame_decoder_core #(
  parameter int FRAME_BYTES = 90
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [9:0] point_angle, [23:10] point_distance
  output logic        out_tuser,  // [0] in_range
  output logic        out_tlast
);
  import lsfd_pkg::*;

  localparam int POS_W = $clog2(FRAME_BYTES);

  logic           ram_we;
  logic [POS_W:0] ram_waddr;
  logic [7:0]     ram_wdata;
  logic [POS_W:0] ram_raddr;
  logic [7:0]     ram_rdata;
  logic           push;
  frame_desc_t    push_desc;
  logic           pop;
  logic           head_valid;
  frame_desc_t    head_desc;
  bank_rel_t      rel;

  lsfd_front #(
    .FRAME_BYTES (FRAME_BYTES),
    .POS_W       (POS_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .push      (push),
    .push_desc (push_desc),
    .rel       (rel)
  );

  lsfd_ram #(
    .WIDTH (8),
    .DEPTH (2 ** (POS_W + 1))
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lsfd_desc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_desc  (push_desc),
    .pop        (pop),
    .head_valid (head_valid),
    .head_desc  (head_desc)
  );

  lsfd_back #(
    .POS_W (POS_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (head_valid),
    .q_desc     (head_desc),
    .q_pop      (pop),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .rel        (rel),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
